@@ rtl/core/ixnz_pkg.sv @@
// Shared types and codes for the indexed nonzero counter.
package ixnz_pkg;

    localparam int IDX_W   = 10;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 31;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // missing_mode codes; any code at or above MODE_POISON marks entries
    localparam logic [1:0] MODE_COUNT  = 2'd0;
    localparam logic [1:0] MODE_IGNORE = 2'd1;
    localparam logic [1:0] MODE_POISON = 2'd2;

    // one accepted beat, value already reduced to a nonzero flag
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic             nonzero;
        logic             missing;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic             missing;
    } res_t;

    // control from the update stage
    typedef struct packed {
        logic wr_en;
        logic res_en;
    } upd_ctl_t;

endpackage

@@ rtl/core/indexed_nonzero_counter.sv @@
// Top level of the indexed nonzero counter: control, clear sweep, forwarding.
//
//  channel  | dir | tdata (low bit up)                  | tuser (low bit up)
//  ---------+-----+-------------------------------------+---------------------------
//  s_*      | in  | entry_index[9:0], element_value[31:0] | op[1:0], element_missing
//  m_*      | out | entry_count[30:0]                   | entry_missing
//  cfg_*    | in  | missing_mode[1:0], write on cfg_we  | -
//
// Flow: a beat is accepted, its entry is read from the store in that edge, and in the
// next cycle the update stage writes it back; one beat per cycle unless stalled.
// A write from the previous edge is forwarded when the next beat hits the same entry.
// Reset: a clear sweep writes zero to every entry, one per cycle; s_tready stays
// low until it ends. missing_mode resets to 1.
// Stalls: reads park in a two-beat result queue; s_tready drops when a read beat
// in flight would find the queue full.
module indexed_nonzero_counter #(
    parameter int ENTRIES    = 1024,
    parameter int COUNT_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[9:0], element_value[41:10], zero pad
    input  logic [2:0]  s_tuser,   // op[1:0], element_missing[2]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // entry_count[30:0], zero pad
    output logic [0:0]  m_tuser,   // entry_missing[0]
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata  // missing_mode
);

    import ixnz_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W = COUNT_BITS + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    logic [1:0]        mode_reg;

    // clear sweep after reset
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // update stage
    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [ADDR_W-1:0] b_addr;
    logic [DATA_W-1:0] b_data;

    // forwarding of the last update write
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    logic              accept;
    item_t             in_item;
    logic [DATA_W-1:0] rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    upd_ctl_t          upd_ctl;
    logic [DATA_W-1:0] upd_wdata;
    res_t              upd_res;

    res_t              q_head;
    logic [1:0]        q_count;
    logic              q_valid;
    logic              pop;
    logic [1:0]        q_after_pop;
    logic              b_read;

    // ---- input side ----
    assign in_item.op      = s_tuser[1:0];
    assign in_item.idx     = s_tdata[IDX_W-1:0];
    assign in_item.nonzero = (s_tdata[IDX_W +: VALUE_W] != '0);
    assign in_item.missing = s_tuser[2];

    // a read in the update stage takes a queue slot at the next edge
    assign pop         = q_valid && m_tready;
    assign q_after_pop = q_count - {1'b0, pop};
    assign b_read      = b_valid_reg && (b_item_reg.op == OP_READ);
    assign s_tready    = !clr_active_reg &&
                         ((q_after_pop == 2'd0) || (q_after_pop == 2'd1 && !b_read));
    assign accept      = s_tvalid && s_tready;

    // ---- store ----
    assign mem_we    = clr_active_reg ? 1'b1 : upd_ctl.wr_en;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : b_addr;
    assign mem_wdata = clr_active_reg ? '0 : upd_wdata;

    ixnz_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W),
        .DEPTH  (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(in_item.idx)),
        .rd_data (rd_data)
    );

    // ---- update stage ----
    assign b_addr = ADDR_W'(b_item_reg.idx);
    assign b_data = (fwd_valid_reg && fwd_addr_reg == b_addr) ? fwd_data_reg : rd_data;

    ixnz_update #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .in_valid (b_valid_reg),
        .item     (b_item_reg),
        .mode     (mode_reg),
        .cur_data (b_data),
        .ctl      (upd_ctl),
        .wr_data  (upd_wdata),
        .res      (upd_res)
    );

    // ---- result queue ----
    ixnz_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (upd_ctl.res_en),
        .push_data (upd_res),
        .ready     (m_tready),
        .valid     (q_valid),
        .head      (q_head),
        .count     (q_count)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = {1'b0, q_head.count};
    assign m_tuser  = q_head.missing;

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IGNORE;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            b_valid_reg   <= accept;
            fwd_valid_reg <= upd_ctl.wr_en;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_item_reg <= in_item;
        end
        if (upd_ctl.wr_en)
        begin
            fwd_addr_reg <= b_addr;
            fwd_data_reg <= upd_wdata;
        end
    end

    // ---- assertions ----
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("beat accepted during clear sweep");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count != 2'd3)
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_ctl.res_en && q_count == 2'd2) |-> pop)
        else $error("result pushed into full queue");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(upd_ctl.wr_en))
        else $error("forward valid without a prior update write");

endmodule

@@ rtl/core/ixnz_store.sv @@
// Counter store: one write port, one registered read port.
module ixnz_store #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-during-write returns the old word; caller forwards
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ixnz_update.sv @@
// Modify step: new entry word for count/clear, result word for read.
module ixnz_update #(
    parameter int ENTRIES    = 1024,
    parameter int COUNT_BITS = 31
) (
    input  logic                  in_valid,
    input  ixnz_pkg::item_t       item,
    input  logic [1:0]            mode,
    input  logic [COUNT_BITS:0]   cur_data,
    output ixnz_pkg::upd_ctl_t    ctl,
    output logic [COUNT_BITS:0]   wr_data,
    output ixnz_pkg::res_t        res
);

    import ixnz_pkg::*;

    logic                  idx_ok;
    logic                  mark;
    logic [COUNT_BITS-1:0] cnt;
    logic                  inc;
    logic [63:0]           cnt_ext;

    assign idx_ok  = ({22'd0, item.idx} < 32'(ENTRIES));
    assign mark    = cur_data[COUNT_BITS];
    assign cnt     = cur_data[COUNT_BITS-1:0];
    assign cnt_ext = 64'(cnt);

    always_comb
    begin
        ctl         = '0;
        wr_data     = cur_data;
        res.count   = '0;
        res.missing = 1'b0;
        inc         = 1'b0;
        case (item.op)
            OP_COUNT:
            begin
                ctl.wr_en = in_valid && idx_ok;
                if (mode >= MODE_POISON && item.missing)
                begin
                    wr_data = {1'b1, {COUNT_BITS{1'b0}}};
                end
                else
                begin
                    if (mode == MODE_COUNT)
                    begin
                        inc = item.missing || item.nonzero;
                    end
                    else
                    begin
                        inc = !item.missing && item.nonzero;
                    end
                    if (inc && !mark && cnt != {COUNT_BITS{1'b1}})
                    begin
                        wr_data = {mark, cnt + COUNT_BITS'(1)};
                    end
                end
            end
            OP_READ:
            begin
                ctl.res_en  = in_valid;
                res.missing = idx_ok && mark;
                if (idx_ok && !mark)
                begin
                    res.count = (cnt_ext > 64'(OUT_MAX)) ? OUT_MAX : cnt_ext[OUT_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                ctl.wr_en = in_valid && idx_ok;
                wr_data   = '0;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/ixnz_outq.sv @@
// Two-entry result queue in front of the master port.
module ixnz_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ixnz_pkg::res_t push_data,
    input  logic           ready,
    output logic           valid,
    output ixnz_pkg::res_t head,
    output logic [1:0]     count
);

    import ixnz_pkg::*;

    res_t       q0_reg, q0_next;
    res_t       q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign pop   = valid && ready;
    assign head  = q0_reg;
    assign count = cnt_reg;

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg - {1'b0, pop} + {1'b0, push};
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    q0_next = push_data;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    q0_next = push_data;
                end
                else if (push)
                begin
                    q1_next = push_data;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    q0_next = q1_reg;
                    if (push)
                    begin
                        q1_next = push_data;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule
